FILE: rtl/core/dsmp_pkg.sv
// ----------------------------------------------------------------------------
// dsmp_pkg
// Shared codes, command type and CV index reduction for the service-mode
// programmer.
// ----------------------------------------------------------------------------
package dsmp_pkg;

    // Store size default and index width of a queued command
    localparam int unsigned CV_COUNT_DEFAULT = 1024;
    localparam int unsigned CMD_IDX_W        = 10;

    // Acknowledge pulse length after reset
    localparam logic [3:0] ACK_TICKS_RESET = 4'd12;

    // Input modes (tuser)
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_PAGED   = 3'd1;
    localparam logic [2:0] MODE_DIRECT  = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_PRELOAD = 3'd4;

    // Command kinds after classification
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_PAGED   = 3'd1;
    localparam logic [2:0] KIND_DIRECT  = 3'd2;
    localparam logic [2:0] KIND_CLEAR   = 3'd3;
    localparam logic [2:0] KIND_PRELOAD = 3'd4;
    localparam logic [2:0] KIND_NONE    = 3'd5;

    // Paged/physical opcodes, low three bits of byte 0
    localparam logic [2:0] OP_PHYS_CV29 = 3'b100;
    localparam logic [2:0] OP_PAGE_REG  = 3'b101;
    localparam logic [2:0] OP_PHYS_CV7  = 3'b110;
    localparam logic [2:0] OP_PHYS_CV8  = 3'b111;

    // Physical register CV numbers
    localparam int unsigned PHYS_CV29 = 29;
    localparam int unsigned PHYS_CV7  = 7;
    localparam int unsigned PHYS_CV8  = 8;

    // Direct-mode instruction, bits 3:2 of byte 0
    localparam logic [1:0] DIR_VERIFY = 2'b01;
    localparam logic [1:0] DIR_WRITE  = 2'b11;

    // Service flag bits
    localparam int unsigned FLAG_PAGE   = 0;
    localparam int unsigned FLAG_VERIFY = 1;
    localparam int unsigned FLAG_WRITE  = 2;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           b0;
        logic [7:0]           b1;
        logic [7:0]           b2;
        logic [7:0]           b3;
        logic [CMD_IDX_W-1:0] idx;    // direct or preload store index
        logic [7:0]           value;  // preload value
    } cmd_t;

    // Reduce a value below 32 * count into 0..count-1 by restoring steps
    function automatic logic [12:0] cv_reduce(input logic [12:0] v,
                                              input int unsigned count);
        logic [14:0] r;
        logic [14:0] step;
        r = {2'b00, v};
        for (int k = 4; k >= 0; k--) begin
            step = 15'(count << k);
            if (r >= step) begin
                r = r - step;
            end
        end
        return r[12:0];
    endfunction

endpackage

FILE: rtl/core/dsmp_front.sv
// ----------------------------------------------------------------------------
// dsmp_front
// Input side: accept items, classify the mode and precompute the store index
// of direct and preload items.
// ----------------------------------------------------------------------------
module dsmp_front #(
    parameter int unsigned CV_COUNT = dsmp_pkg::CV_COUNT_DEFAULT
) (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [55:0]    s_tdata,
    input  logic [2:0]     s_tuser,
    input  logic           clearing,
    input  logic           q_full,
    output logic           q_push,
    output dsmp_pkg::cmd_t q_data
);
    import dsmp_pkg::*;

    logic [2:0]  kind;
    logic [12:0] pre_sum;
    logic [12:0] dir_sum;
    logic [12:0] idx_full;

    always_comb begin
        case (s_tuser)
            MODE_TICK:    kind = KIND_TICK;
            MODE_PAGED:   kind = KIND_PAGED;
            MODE_DIRECT:  kind = KIND_DIRECT;
            MODE_CLEAR:   kind = KIND_CLEAR;
            MODE_PRELOAD: kind = KIND_PRELOAD;
            default:      kind = KIND_NONE;
        endcase
    end

    // CV number minus one, wrapped into the store
    assign pre_sum  = 13'(s_tdata[42:32]) + 13'(CV_COUNT - 1);
    assign dir_sum  = {3'b000, s_tdata[1:0], s_tdata[15:8]};
    assign idx_full = cv_reduce((kind == KIND_PRELOAD) ? pre_sum : dir_sum, CV_COUNT);

    always_comb begin
        q_data.kind  = kind;
        q_data.b0    = s_tdata[7:0];
        q_data.b1    = s_tdata[15:8];
        q_data.b2    = s_tdata[23:16];
        q_data.b3    = s_tdata[31:24];
        q_data.idx   = idx_full[CMD_IDX_W-1:0];
        q_data.value = s_tdata[50:43];
    end

    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready;

endmodule

FILE: rtl/core/dsmp_queue.sv
// ----------------------------------------------------------------------------
// dsmp_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module dsmp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dsmp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output dsmp_pkg::cmd_t head
);
    import dsmp_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop && valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/dsmp_back.sv
// ----------------------------------------------------------------------------
// dsmp_back
// Execution side: CV store, packet cache, service flags, acknowledge timer
// and the result register.
// ----------------------------------------------------------------------------
module dsmp_back #(
    parameter int unsigned CV_COUNT = dsmp_pkg::CV_COUNT_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [3:0]     cfg_data,
    input  logic           q_valid,
    input  dsmp_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           clearing,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata
);
    import dsmp_pkg::*;

    localparam int unsigned IDX_W = $clog2(CV_COUNT);
    localparam logic [IDX_W-1:0] CV29_IDX = IDX_W'((PHYS_CV29 - 1) % CV_COUNT);
    localparam logic [IDX_W-1:0] CV7_IDX  = IDX_W'((PHYS_CV7 - 1) % CV_COUNT);
    localparam logic [IDX_W-1:0] CV8_IDX  = IDX_W'((PHYS_CV8 - 1) % CV_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CV_COUNT - 1);
    localparam logic [12:0] PAGE_BIAS = 13'(4 * CV_COUNT - 4);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [7:0]       mem [CV_COUNT];
    logic [7:0]       rd_data_reg;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [3:0]       pulse_ticks_reg;
    logic [7:0]       cache_reg [4];
    logic [7:0]       cache_next [4];
    logic             done_reg;
    logic             done_next;
    logic [3:0]       cnt_reg;
    logic [3:0]       cnt_next;
    logic [7:0]       page_reg;
    logic [7:0]       page_next;
    logic [2:0]       flags_reg;
    logic [2:0]       flags_next;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;

    logic [12:0]      paged_sum;
    logic [12:0]      paged_red;
    logic [IDX_W-1:0] fetch_idx;
    logic             exec_go;
    logic             hit3;
    logic             hit4;
    logic [4:0]       tick_next;
    logic             started;
    logic             wrote;
    logic [7:0]       wr_val;
    logic [10:0]      wr_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;

    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_FETCH) && q_valid;
    assign exec_go  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    // Store index of the head command, page register is final here
    assign paged_sum = {3'b000, page_reg, 2'b00} + 13'(q_head.b0[1:0]) + PAGE_BIAS;
    assign paged_red = cv_reduce(paged_sum, CV_COUNT);

    always_comb begin
        fetch_idx = q_head.idx[IDX_W-1:0];
        if (q_head.kind == KIND_PAGED) begin
            if (!q_head.b0[2]) begin
                fetch_idx = paged_red[IDX_W-1:0];
            end else begin
                case (q_head.b0[2:0])
                    OP_PHYS_CV29: fetch_idx = CV29_IDX;
                    OP_PHYS_CV7:  fetch_idx = CV7_IDX;
                    default:      fetch_idx = CV8_IDX;
                endcase
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == LAST_IDX) state_next = ST_FETCH;
            ST_FETCH: if (q_valid) state_next = ST_EXEC;
            ST_EXEC:  if (exec_go) state_next = ST_FETCH;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Command outcome
    assign hit3 = (cmd_reg.b0 == cache_reg[0]) && (cmd_reg.b1 == cache_reg[1]) &&
                  (cmd_reg.b2 == cache_reg[2]);
    assign hit4 = hit3 && (cmd_reg.b3 == cache_reg[3]);
    assign tick_next = {1'b0, cnt_reg} + 5'd1;

    always_comb begin
        cache_next = cache_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        page_next  = page_reg;
        flags_next = flags_reg;
        started    = 1'b0;
        wrote      = 1'b0;
        wr_val     = 8'd0;
        case (cmd_reg.kind)
            KIND_TICK: begin
                if (cnt_reg != 4'd0) begin
                    if (tick_next > {1'b0, pulse_ticks_reg} || tick_next > 5'd15) begin
                        cnt_next  = 4'd0;
                        done_next = 1'b1;
                    end else begin
                        cnt_next = tick_next[3:0];
                    end
                end
            end
            KIND_PAGED: begin
                if (!hit3) begin
                    cache_next[0] = cmd_reg.b0;
                    cache_next[1] = cmd_reg.b1;
                    cache_next[2] = cmd_reg.b2;
                    done_next     = 1'b0;
                end else if (!cmd_reg.b0[2]) begin
                    if (cmd_reg.b0[3]) begin
                        wrote                 = 1'b1;
                        wr_val                = cmd_reg.b1;
                        flags_next[FLAG_WRITE] = 1'b1;
                        started               = 1'b1;
                    end else if (cmd_reg.b1 == rd_data_reg) begin
                        flags_next[FLAG_VERIFY] = 1'b1;
                        started                 = 1'b1;
                    end
                end else if (cmd_reg.b0[2:0] == OP_PAGE_REG) begin
                    if (!flags_reg[FLAG_PAGE]) begin
                        page_next             = cmd_reg.b1;
                        flags_next[FLAG_PAGE] = 1'b1;
                        started               = 1'b1;
                    end
                end else if (cmd_reg.b0[3]) begin
                    wrote  = 1'b1;
                    wr_val = cmd_reg.b1;
                    if (!flags_reg[FLAG_WRITE]) begin
                        flags_next[FLAG_WRITE] = 1'b1;
                        started                = 1'b1;
                    end
                end else if (cmd_reg.b1 == rd_data_reg) begin
                    if (!flags_reg[FLAG_VERIFY]) begin
                        flags_next[FLAG_VERIFY] = 1'b1;
                        started                 = 1'b1;
                    end
                end
            end
            KIND_DIRECT: begin
                if (!hit4) begin
                    cache_next[0] = cmd_reg.b0;
                    cache_next[1] = cmd_reg.b1;
                    cache_next[2] = cmd_reg.b2;
                    cache_next[3] = cmd_reg.b3;
                    done_next     = 1'b0;
                end else if (!done_reg) begin
                    case (cmd_reg.b0[3:2])
                        DIR_VERIFY: begin
                            if (cmd_reg.b2 == rd_data_reg) started = 1'b1;
                        end
                        DIR_WRITE: begin
                            wrote   = 1'b1;
                            wr_val  = cmd_reg.b2;
                            started = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_CLEAR: flags_next = 3'b000;
            KIND_PRELOAD: begin
                wrote  = 1'b1;
                wr_val = cmd_reg.value;
            end
            default: ;
        endcase
        if (started) begin
            cnt_next  = 4'd1;
            done_next = 1'b1;
        end
    end

    assign wr_addr = wrote ? (11'(idx_reg) + 11'd1) : 11'd0;

    // Single write port serves the clearing pass and command writes
    assign mem_we    = clearing || (exec_go && wrote);
    assign mem_waddr = clearing ? clr_cnt_reg : idx_reg;
    assign mem_wdata = clearing ? 8'd0 : wr_val;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[fetch_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            pulse_ticks_reg <= ACK_TICKS_RESET;
            for (int i = 0; i < 4; i++) begin
                cache_reg[i] <= 8'd0;
            end
            done_reg        <= 1'b0;
            cnt_reg         <= 4'd0;
            page_reg        <= 8'd0;
            flags_reg       <= 3'b000;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                pulse_ticks_reg <= cfg_data;
            end
            if (exec_go) begin
                cache_reg    <= cache_next;
                done_reg     <= done_next;
                cnt_reg      <= cnt_next;
                page_reg     <= page_next;
                flags_reg    <= flags_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
            idx_reg <= fetch_idx;
        end
        if (exec_go) begin
            m_tdata_reg <= {2'b00, page_next, wr_val, wr_addr, wrote, started,
                            (cnt_next != 4'd0)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/dcc_service_mode_programmer.sv
// ----------------------------------------------------------------------------
// dcc_service_mode_programmer
// DCC service-mode programming with acknowledge pulse: paged, physical and
// direct CV access against an internal CV store, ticks and CV preloads.
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------
// s_       | in        | s_tvalid / s_tready  | s_tuser mode, s_tdata bytes
// m_       | out       | m_tvalid / m_tready  | m_tdata result
// cfg_     | in        | cfg_valid / cfg_ready| cfg_data ack_pulse_ticks
//
// In the execution side each item passes a fetch state, which reads the CV
// memory port at the item's store index, then an execute state, which
// compares, writes back and registers the result. The front keeps taking
// items into a two-entry queue meanwhile. After reset the CV store is
// cleared, one entry a cycle, from index 0 to CV_COUNT-1; s_tready stays low
// during that pass. cfg_ready is always high. A stalled m_ side holds its
// result and lets the queue fill before s_tready drops.
// ----------------------------------------------------------------------------
module dcc_service_mode_programmer #(
    parameter int unsigned CV_COUNT = dsmp_pkg::CV_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pkt_byte0, pkt_byte1, pkt_byte2, pkt_byte3, preload_address[10:0],
    // preload_value[7:0], zero fill
    input  logic [55:0] s_tdata,
    // mode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ack_active, ack_started, cv_write_done, cv_write_address[10:0],
    // cv_write_value[7:0], page_value[7:0], zero fill
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import dsmp_pkg::*;

    cmd_t push_data;
    cmd_t head;
    logic push;
    logic full;
    logic pop;
    logic q_valid;
    logic clearing;

    // Configuration lands the same cycle it is offered
    assign cfg_ready = 1'b1;

    // Classify and precompute store indexes
    dsmp_front #(
        .CV_COUNT (CV_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    // Decouple acceptance from execution
    dsmp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (head)
    );

    // Execute commands against the store and hold the result
    dsmp_back #(
        .CV_COUNT (CV_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_head   (head),
        .q_pop    (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A started pulse is always active in the same result
    a_started_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("ack_started without ack_active");

    // No write means a zero address and value
    a_idle_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[21:3] == 19'd0))
        else $error("write address or value set without a write");

    // A write always reports a CV number from one up
    a_write_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[13:3] != 11'd0))
        else $error("write reported at CV zero");

    // Right after reset the store is being cleared, so no input is taken
    a_clear_blocks: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input accepted during the clearing pass");

endmodule
